// ----- hw/rtl/sorted_key_index_table_assert.svh -----
// Assertion macros used by the checker file of the sorted key index table.
`ifndef SORTED_KEY_INDEX_TABLE_ASSERT_SVH
`define SORTED_KEY_INDEX_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKIT_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted key index table: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SKIT_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted key index table: assertion failed");

`endif

// ----- hw/rtl/skit_pkg.sv -----
`timescale 1ns / 1ps

package skit_pkg;

	localparam int KEY_W    = 56;
	localparam int ADDR_W   = 24;
	localparam int STATUS_W = 2;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Result status codes.
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_ENTRY = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	// Command codes.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DUMP   = 1'b1;

	// Outcome of one step of the compare unit.
	typedef struct packed {
		logic lt;   // new key sorts below the stored key
		logic more; // entries remain below the slot after moving down
	} cmp_res_t;

endpackage

// ----- hw/rtl/skit_in_if.sv -----
`timescale 1ns / 1ps

interface skit_in_if;
	logic             valid;
	logic             ready;
	logic             cmd;
	skit_pkg::key_t   key;
	skit_pkg::addr_t  address;

	modport source (output valid, output cmd, output key, output address, input ready);
	modport sink   (input valid, input cmd, input key, input address, output ready);
endinterface

// ----- hw/rtl/skit_out_if.sv -----
`timescale 1ns / 1ps

interface skit_out_if;
	logic              valid;
	logic              ready;
	skit_pkg::status_t status;
	skit_pkg::key_t    key_out;
	skit_pkg::addr_t   address_out;
	logic              last;

	modport source (output valid, output status, output key_out, output address_out,
		output last, input ready);
	modport sink   (input valid, input status, input key_out, input address_out,
		input last, output ready);
endinterface

// ----- hw/rtl/skit_mem.sv -----
`timescale 1ns / 1ps

// Entry store: one write port, one read port with registered read data.
module skit_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 80
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/skit_cmp_unit.sv -----
`timescale 1ns / 1ps

// Compare unit: key compare plus the slot pointer step of the insert walk.
module skit_cmp_unit #(
	parameter int KEY_BITS = 56,
	parameter int CW       = 6
) (
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [KEY_BITS-1:0] stored_key,
	input  logic [CW-1:0]       slot,
	output skit_pkg::cmp_res_t  res,
	output logic [CW-1:0]       slot_dec
);

	always_comb begin
		slot_dec = slot - CW'(1);
		res.lt   = (new_key < stored_key);
		res.more = (slot_dec != '0);
	end

endmodule

// ----- hw/rtl/sorted_key_index_table.sv -----
// Sorted key index table.
// The item channel carries beats of (cmd, key, address). An insert beat places
// the entry after every stored entry whose key is less than or equal to it and
// answers with one status beat: ok, or full when the table already holds DEPTH
// entries, in which case the entry is dropped. A dump beat answers with one
// beat per stored entry in ascending key order, the last one marked, or with a
// single empty beat when the table holds nothing.
// Timing: an insert walks down from the top of the table, one entry per cycle
// through the single memory read port and the compare unit, moving each stored
// entry whose key is larger up by one slot. A dump streams one entry per cycle
// while the receiver takes each beat, once a start state has read the first
// entry. The item channel takes a new beat only when the sequencer is idle,
// which it is again as soon as the last result of the previous beat sits in
// the output register. A stalled receiver holds the output register and
// freezes the dump walk; no result is lost or repeated. Reset empties the
// table at once (the entry count is cleared); memory contents are not
// cleared and are never read before they are written.
`timescale 1ns / 1ps

module sorted_key_index_table #(
	parameter int DEPTH     = 32,
	parameter int KEY_CHARS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	skit_in_if.sink     item,
	skit_out_if.source  result
);

	// Only the low min(8*KEY_CHARS, KEY_W) bits of a key are kept and compared.
	localparam int KEY_BITS = (KEY_CHARS * 8 < skit_pkg::KEY_W) ? KEY_CHARS * 8
		: skit_pkg::KEY_W;
	localparam int ENTRY_W  = KEY_BITS + skit_pkg::ADDR_W;
	localparam int CW       = $clog2(DEPTH + 1);
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_RD  = 3'd1;
	localparam logic [2:0] S_INS_CMP = 3'd2;
	localparam logic [2:0] S_INS_WR  = 3'd3;
	localparam logic [2:0] S_DMP_RD  = 3'd4;
	localparam logic [2:0] S_DMP_OUT = 3'd5;
	localparam logic [2:0] S_RES     = 3'd6;

	logic [2:0]          state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	// Open slot during an insert, read index during a dump.
	logic [CW-1:0]       slot_q, slot_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	skit_pkg::addr_t     addr_q, addr_d;
	skit_pkg::status_t   pend_status_q, pend_status_d;

	// Output register, which parts the sequencer from the receiver.
	logic                out_valid_q, out_valid_d;
	skit_pkg::status_t   out_status_q, out_status_d;
	skit_pkg::key_t      out_key_q, out_key_d;
	skit_pkg::addr_t     out_addr_q, out_addr_d;
	logic                out_last_q, out_last_d;

	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0]  mem_wdata, mem_rdata;

	skit_pkg::cmp_res_t  cmp_res;
	logic [CW-1:0]       slot_dec;
	logic [CW-1:0]       slot_inc;
	logic                slot_free;
	logic                accept;

	skit_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The stored entry just read is compared against the key being inserted.
	skit_cmp_unit #(
		.KEY_BITS (KEY_BITS),
		.CW       (CW)
	) u_cmp (
		.new_key    (key_q),
		.stored_key (mem_rdata[ENTRY_W-1:skit_pkg::ADDR_W]),
		.slot       (slot_q),
		.res        (cmp_res),
		.slot_dec   (slot_dec)
	);

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && (state_q == S_IDLE);
	assign slot_free  = !out_valid_q || result.ready;
	assign slot_inc   = slot_q + CW'(1);

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		slot_d        = slot_q;
		key_d         = key_q;
		addr_d        = addr_q;
		pend_status_d = pend_status_q;
		out_valid_d   = out_valid_q && !result.ready;
		out_status_d  = out_status_q;
		out_key_d     = out_key_q;
		out_addr_d    = out_addr_q;
		out_last_d    = out_last_q;
		mem_we        = 1'b0;
		mem_waddr     = AW'(slot_q);
		mem_wdata     = {key_q, addr_q};
		mem_re        = 1'b0;
		mem_raddr     = AW'(slot_q);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_d  = item.key[KEY_BITS-1:0];
					addr_d = item.address;
					if (item.cmd == skit_pkg::CMD_INSERT) begin
						if (count_q == CW'(DEPTH)) begin
							pend_status_d = skit_pkg::ST_FULL;
							state_d       = S_RES;
						end else begin
							slot_d  = count_q;
							state_d = S_INS_RD;
						end
					end else begin
						if (count_q == '0) begin
							pend_status_d = skit_pkg::ST_EMPTY;
							state_d       = S_RES;
						end else begin
							slot_d  = '0;
							state_d = S_DMP_RD;
						end
					end
				end
			end
			S_INS_RD: begin
				// Fetch the entry just below the open slot, if there is one.
				if (slot_q == '0) begin
					state_d = S_INS_WR;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(slot_dec);
					state_d   = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				// A larger entry moves up into the open slot while the next one
				// down is fetched in the same cycle.
				if (cmp_res.lt) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
					slot_d    = slot_dec;
					if (cmp_res.more) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(slot_dec - CW'(1));
					end else begin
						state_d = S_INS_WR;
					end
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				mem_we        = 1'b1;
				count_d       = count_q + CW'(1);
				pend_status_d = skit_pkg::ST_OK;
				state_d       = S_RES;
			end
			S_DMP_RD: begin
				mem_re  = 1'b1;
				state_d = S_DMP_OUT;
			end
			S_DMP_OUT: begin
				// Read data holds while the receiver stalls, since no new read
				// is issued until the entry moves into the output register.
				if (slot_free) begin
					out_valid_d  = 1'b1;
					out_status_d = skit_pkg::ST_ENTRY;
					out_key_d    = skit_pkg::key_t'(mem_rdata[ENTRY_W-1:skit_pkg::ADDR_W]);
					out_addr_d   = mem_rdata[skit_pkg::ADDR_W-1:0];
					out_last_d   = (slot_inc == count_q);
					if (slot_inc == count_q) begin
						state_d = S_IDLE;
					end else begin
						slot_d    = slot_inc;
						mem_re    = 1'b1;
						mem_raddr = AW'(slot_inc);
					end
				end
			end
			S_RES: begin
				if (slot_free) begin
					out_valid_d  = 1'b1;
					out_status_d = pend_status_q;
					out_key_d    = '0;
					out_addr_d   = '0;
					out_last_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q        <= slot_d;
		key_q         <= key_d;
		addr_q        <= addr_d;
		pend_status_q <= pend_status_d;
		out_status_q  <= out_status_d;
		out_key_q     <= out_key_d;
		out_addr_q    <= out_addr_d;
		out_last_q    <= out_last_d;
	end

	assign result.valid       = out_valid_q;
	assign result.status      = out_status_q;
	assign result.key_out     = out_key_q;
	assign result.address_out = out_addr_q;
	assign result.last        = out_last_q;

endmodule

// ----- hw/rtl/skit_checker.sv -----
`timescale 1ns / 1ps
`include "sorted_key_index_table_assert.svh"

// Port level checks of the sorted key index table.
module skit_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input skit_pkg::status_t status,
	input skit_pkg::key_t    key_out,
	input skit_pkg::addr_t   address_out,
	input logic              last
);

	// A result beat waits until it is taken.
	`SKIT_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid)

	// A stalled result keeps its payload.
	`SKIT_ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && !result_ready, $stable(status) && $stable(key_out) && $stable(address_out) && $stable(last))

	// Status-only results are single beats carrying no entry.
	`SKIT_ASSERT_NOW(a_status_only, clk, arst_n, result_valid && status != skit_pkg::ST_ENTRY, last && key_out == '0 && address_out == '0)

	// The block works on one command at a time.
	`SKIT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, item_valid && item_ready, !item_ready)

endmodule

bind sorted_key_index_table skit_checker u_skit_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.status       (result.status),
	.key_out      (result.key_out),
	.address_out  (result.address_out),
	.last         (result.last)
);
